FILE: rtl/vfpf_pkg.sv
package vfpf_pkg;

  // one point per request
  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    logic               withheld;
    logic               new_cloud;
  } point_t;

  typedef enum logic [1:0] {
    V_KEPT     = 2'd0,
    V_DUP      = 2'd1,
    V_WITHHELD = 2'd2,
    V_OUTSIDE  = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [19:0] voxel_index;
  } result_t;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t REG_ORIGIN_X    = 3'd0;
  localparam cfg_index_t REG_ORIGIN_Y    = 3'd1;
  localparam cfg_index_t REG_ORIGIN_Z    = 3'd2;
  localparam cfg_index_t REG_CELL_SIZE   = 3'd3;
  localparam cfg_index_t REG_GRID_WIDTH  = 3'd4;
  localparam cfg_index_t REG_GRID_HEIGHT = 3'd5;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned CELL_W  = 21;
  localparam int unsigned DIM_W   = 13;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_INDEX,
    ST_READ,
    ST_WRITE,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/vfpf_divider.sv
module vfpf_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [20:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  import vfpf_pkg::*;

  // restoring radix-2, one quotient bit per cycle
  logic [31:0] num;
  logic [20:0] rem;
  logic [20:0] div;
  logic [4:0]  cnt;
  logic [21:0] shifted;
  logic        fits;

  assign shifted  = {rem, num[COORD_W-1]};
  assign fits     = shifted >= {1'b0, div};
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      div <= divisor;
    end else if (busy) begin
      num <= {num[COORD_W-2:0], fits};
      rem <= fits ? 21'(shifted - {1'b0, div}) : shifted[20:0];
    end
  end

endmodule

FILE: rtl/voxel_first_point_filter.sv
// channel  | direction | handshake                   | payload
// point    | in        | point_valid / point_ready   | vfpf_pkg::point_t
// result   | out       | result_valid / result_ready | vfpf_pkg::result_t
// cfg      | in        | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// one point at a time; a point that reaches the bitmap passes the idle state
// that takes it, the divide state (32 shift steps of the three radix-2
// dividers, one per axis, run side by side), two multiply stages, an index
// stage, a read then write of the occupancy word, and the output load; a
// withheld point goes from idle to the output load, one outside from the
// divide or the index stage; after reset and on every point with new_cloud set,
// a clearing pass writes zero to each of the (VOXEL_CAPACITY+63)/64 bitmap
// words, one per cycle (16384 at the default) while point_ready stays low
// a finished result waits in the output register; the next point is taken
// meanwhile, and its result waits only if the register is still full
module voxel_first_point_filter #(
  parameter int unsigned VOXEL_CAPACITY = 1048576
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 point_valid,
  output logic                 point_ready,
  input  vfpf_pkg::point_t     point,
  output logic                 result_valid,
  input  logic                 result_ready,
  output vfpf_pkg::result_t    result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  vfpf_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_data
);
  import vfpf_pkg::*;

  // bitmap geometry
  localparam int unsigned WORDS = (VOXEL_CAPACITY + 63) / 64;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned IW    = $clog2(VOXEL_CAPACITY);
  localparam int unsigned PW1   = DIM_W + IW;
  localparam int unsigned PW2   = PW1 + 1 + DIM_W;
  localparam int unsigned SW    = PW2 + 1;

  // configuration registers
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic [CELL_W-1:0]  cell_size;
  logic [DIM_W-1:0]   grid_width;
  logic [DIM_W-1:0]   grid_height;

  state_t state, state_next;

  logic            accept;
  logic            held;
  logic            withheld_r;
  logic            neg_x, neg_y, neg_z;
  verdict_t        verdict_r;
  logic [DIM_W-1:0] qx, qy;
  logic [IW-1:0]   qz;
  logic [PW1-1:0]  prod1;
  logic [PW2-1:0]  prod2;
  logic [SW-1:0]   idx_full;
  logic [IW-1:0]   idx;
  logic [AW-1:0]   clr_addr;
  logic            clr_last;
  logic            slot_free;
  logic            emit_load;
  logic            outside_div;

  // divider lanes
  logic [32:0]        off_x, off_y, off_z;
  logic [CELL_W-1:0]  divisor;
  logic [31:0]        q_x, q_y, q_z;
  logic               busy_x, busy_y, busy_z;

  // bitmap memory
  logic [63:0]   mem [WORDS];
  logic [63:0]   rd_data;
  logic [AW-1:0] word_addr;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic [63:0]   bit_mask;
  logic          bit_hit;
  logic          mem_we;

  assign cfg_ready = 1'b1;
  assign accept    = point_valid && point_ready;
  assign slot_free = !result_valid || result_ready;
  assign clr_last  = clr_addr == AW'(WORDS - 1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
      cell_size   <= CELL_W'(1);
      grid_width  <= DIM_W'(64);
      grid_height <= DIM_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X:    origin_x    <= cfg_data;
        REG_ORIGIN_Y:    origin_y    <= cfg_data;
        REG_ORIGIN_Z:    origin_z    <= cfg_data;
        REG_CELL_SIZE:   cell_size   <= cfg_data[CELL_W-1:0];
        REG_GRID_WIDTH:  grid_width  <= cfg_data[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // offsets from the origin; a negative offset marks the point as outside
  assign off_x   = {point.x_coord[31], point.x_coord} - {origin_x[31], origin_x};
  assign off_y   = {point.y_coord[31], point.y_coord} - {origin_y[31], origin_y};
  assign off_z   = {point.z_coord[31], point.z_coord} - {origin_z[31], origin_z};
  assign divisor = (cell_size == '0) ? CELL_W'(1) : cell_size;

  vfpf_divider u_div_x (
    .clk(clk), .rst(rst), .start(accept),
    .dividend(off_x[32] ? 32'd0 : off_x[31:0]), .divisor(divisor),
    .busy(busy_x), .quotient(q_x)
  );
  vfpf_divider u_div_y (
    .clk(clk), .rst(rst), .start(accept),
    .dividend(off_y[32] ? 32'd0 : off_y[31:0]), .divisor(divisor),
    .busy(busy_y), .quotient(q_y)
  );
  vfpf_divider u_div_z (
    .clk(clk), .rst(rst), .start(accept),
    .dividend(off_z[32] ? 32'd0 : off_z[31:0]), .divisor(divisor),
    .busy(busy_z), .quotient(q_z)
  );

  // a negative offset, cell coordinates beyond the grid, or a z layer past the capacity
  assign outside_div = neg_x || neg_y || neg_z ||
                       (q_x >= {19'd0, grid_width}) ||
                       (q_y >= {19'd0, grid_height}) ||
                       (q_z >= 32'(VOXEL_CAPACITY));

  assign idx_full = SW'(prod2) + SW'(qx);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          if (!held) state_next = ST_IDLE;
          else if (withheld_r) state_next = ST_EMIT;
          else state_next = ST_DIV;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (point.new_cloud) state_next = ST_CLEAR;
          else if (point.withheld) state_next = ST_EMIT;
          else state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!busy_x && !busy_y && !busy_z) begin
          state_next = outside_div ? ST_EMIT : ST_MUL1;
        end
      end
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_INDEX;
      ST_INDEX: state_next = (idx_full < SW'(VOXEL_CAPACITY)) ? ST_READ : ST_EMIT;
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    point_ready = 1'b0;
    emit_load   = 1'b0;
    mem_we      = 1'b0;
    unique case (state)
      ST_IDLE:  point_ready = 1'b1;
      ST_CLEAR: mem_we      = 1'b1;
      ST_WRITE: mem_we      = !bit_hit;
      ST_EMIT:  emit_load   = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      held  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) held <= 1'b1;
      else if (emit_load) held <= 1'b0;
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_last ? '0 : clr_addr + AW'(1);
    end
  end

  // per-point datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      withheld_r <= point.withheld;
      neg_x      <= off_x[32];
      neg_y      <= off_y[32];
      neg_z      <= off_z[32];
      verdict_r  <= point.withheld ? V_WITHHELD : V_OUTSIDE;
    end
    if (state == ST_DIV) begin
      qx <= q_x[DIM_W-1:0];
      qy <= q_y[DIM_W-1:0];
      qz <= IW'(q_z);
    end
    if (state == ST_MUL1) begin
      prod1 <= PW1'(grid_height * qz);
    end
    if (state == ST_MUL2) begin
      prod2 <= PW2'(grid_width * (PW1 + 1)'(PW1'(qy) + prod1));
    end
    if (state == ST_INDEX) begin
      idx <= IW'(idx_full);
    end
    if (state == ST_WRITE) begin
      verdict_r <= bit_hit ? V_DUP : V_KEPT;
    end
  end

  // occupancy bitmap: read every cycle at the point's word, write back at most once
  assign word_addr = AW'(idx >> 6);
  assign bit_mask  = 64'd1 << idx[5:0];
  assign bit_hit   = (rd_data & bit_mask) != 64'd0;
  assign wr_addr   = (state == ST_CLEAR) ? clr_addr : word_addr;
  assign wr_data   = (state == ST_CLEAR) ? 64'd0 : (rd_data | bit_mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[word_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      result.verdict     <= verdict_r;
      result.voxel_index <= (verdict_r == V_KEPT || verdict_r == V_DUP) ?
                            20'(idx) : 20'd0;
    end
  end

  // a result is only loaded into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit_load |-> (!result_valid || result_ready))
    else $error("result loaded over a waiting result");

  // write-back always follows the read of the same word
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> ($past(state) == ST_READ))
    else $error("bitmap write without preceding read");

  // no point is taken during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !point_ready)
    else $error("point accepted during clearing pass");

  // only kept or duplicate results carry an index
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.verdict != V_KEPT && result.verdict != V_DUP)
      |-> (result.voxel_index == 20'd0))
    else $error("index on a result without a voxel");

endmodule
